// ===== rtl/rfla_pkg.sv =====
package rfla_pkg;

  localparam int REG_W     = 8;
  localparam int CNT_W     = 9;
  localparam int REG_SPACE = 256;

  localparam logic [1:0] OP_GET   = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_HELD      = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             protect_flag;
    logic [REG_W-1:0] reg_in;
    logic             force_flag;
  } req_t;

  typedef struct packed {
    logic [REG_W-1:0] reg_out;
    logic [1:0]       status;
  } res_t;

  typedef struct packed {
    logic             clr;
    logic             push;
    logic             pop;
    logic [REG_W-1:0] data;
  } stk_ctl_t;

  typedef struct packed {
    logic [REG_W-1:0] top;
    logic             empty;
    logic             full;
  } stk_st_t;

  typedef struct packed {
    logic             clr_all;
    logic             set_en;
    logic [REG_W-1:0] set_idx;
    logic             clr_en;
    logic [REG_W-1:0] clr_idx;
  } prot_ctl_t;

endpackage

// ===== rtl/rfla_stack.sv =====
module rfla_stack #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  rfla_pkg::stk_ctl_t ctl,
  output rfla_pkg::stk_st_t  st
);

  localparam int DW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  // top entry held in a register; entries below it live in the memory
  logic [rfla_pkg::REG_W-1:0] mem [DEPTH];

  logic [DW-1:0]              depth;
  logic [DW-1:0]              depth_next;
  logic [rfla_pkg::REG_W-1:0] top;
  logic [rfla_pkg::REG_W-1:0] top_next;
  logic [rfla_pkg::REG_W-1:0] rd_data;
  logic                       byp_valid;
  logic [rfla_pkg::REG_W-1:0] byp_data;
  logic [rfla_pkg::REG_W-1:0] below;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [DW-1:0]              wr_addr_full;
  logic [DW-1:0]              rd_addr_full;
  logic [AW-1:0]              rd_addr;

  assign below = byp_valid ? byp_data : rd_data;

  always_comb begin
    depth_next   = depth;
    top_next     = top;
    wr_en        = 1'b0;
    wr_addr_full = depth - DW'(1);
    if (ctl.clr) begin
      depth_next = '0;
    end else if (ctl.push) begin
      wr_en      = (depth != '0);
      top_next   = ctl.data;
      depth_next = depth + DW'(1);
    end else if (ctl.pop) begin
      top_next   = below;
      depth_next = depth - DW'(1);
    end
  end

  assign wr_addr      = wr_addr_full[AW-1:0];
  assign rd_addr_full = depth_next - DW'(2);
  assign rd_addr      = rd_addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top;
    end
    rd_data   <= mem[rd_addr];
    byp_valid <= wr_en && (wr_addr == rd_addr);
    byp_data  <= top;
    top       <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

  assign st.top   = top;
  assign st.empty = (depth == '0);
  assign st.full  = (depth == DW'(DEPTH));

endmodule

// ===== rtl/rfla_prot.sv =====
module rfla_prot (
  input  logic                       clk,
  input  logic                       rst,
  input  rfla_pkg::prot_ctl_t        ctl,
  input  logic [rfla_pkg::REG_W-1:0] idx,
  output logic                       hit
);

  logic [rfla_pkg::REG_SPACE-1:0] bits;
  logic [rfla_pkg::REG_SPACE-1:0] bits_next;

  always_comb begin
    bits_next = bits;
    if (ctl.clr_all) begin
      bits_next = '0;
    end else begin
      if (ctl.set_en) begin
        bits_next[ctl.set_idx] = 1'b1;
      end
      if (ctl.clr_en) begin
        bits_next[ctl.clr_idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
    end else begin
      bits <= bits_next;
    end
  end

  assign hit = bits[idx];

endmodule

// ===== rtl/register_free_list_allocator.sv =====
// Register number allocator with a LIFO free stack and a fresh-number counter.
// Request channel: a beat (req) is taken on a rising edge with start high and
// busy low; busy is never raised, so a request may be issued every cycle.
// Result channel: done pulses for one cycle with res valid; the receiver
// cannot stall, so every result must be taken in the cycle it is shown.
// The result passes the request register, then the result register.
// Throughput: one request per cycle; the stack top sits in a register and
// the next entry down is prefetched from the stack memory every cycle, so a
// pop or push completes in a single pass.
// Requests: get pops the stack, else hands out the next fresh number, and
// may protect it; free pushes unless the number is protected (force clears
// the protection); reset request clears counter, stack and protection map;
// opcode 3 gives an empty ok result.
// Reset (rst, synchronous): counter, stack depth and protection map cleared,
// no result pending. Stack contents need no clearing.
module register_free_list_allocator #(
  parameter int NUM_REGS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  rfla_pkg::req_t req,
  output logic           done,
  output rfla_pkg::res_t res
);

  localparam int LIMIT = (NUM_REGS > rfla_pkg::REG_SPACE) ? rfla_pkg::REG_SPACE : NUM_REGS;

  logic                       req_valid;
  rfla_pkg::req_t             req_q;
  logic [rfla_pkg::CNT_W-1:0] fresh;
  logic [rfla_pkg::CNT_W-1:0] fresh_next;
  rfla_pkg::stk_ctl_t         stk_ctl;
  rfla_pkg::stk_st_t          stk_st;
  rfla_pkg::prot_ctl_t        prot_ctl;
  logic                       prot_hit;
  rfla_pkg::res_t             res_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
  end

  rfla_stack #(.DEPTH(LIMIT)) u_stack (
    .clk (clk),
    .rst (rst),
    .ctl (stk_ctl),
    .st  (stk_st)
  );

  rfla_prot u_prot (
    .clk (clk),
    .rst (rst),
    .ctl (prot_ctl),
    .idx (req_q.reg_in),
    .hit (prot_hit)
  );

  always_comb begin
    fresh_next = fresh;
    stk_ctl    = '0;
    prot_ctl   = '0;
    res_next   = '0;
    stk_ctl.data     = req_q.reg_in;
    prot_ctl.clr_idx = req_q.reg_in;
    if (req_valid) begin
      case (req_q.req_type)
        rfla_pkg::OP_GET: begin
          if (!stk_st.empty) begin
            stk_ctl.pop      = 1'b1;
            res_next.reg_out = stk_st.top;
            prot_ctl.set_en  = req_q.protect_flag;
          end else if (fresh < rfla_pkg::CNT_W'(LIMIT)) begin
            res_next.reg_out = fresh[rfla_pkg::REG_W-1:0];
            fresh_next       = fresh + rfla_pkg::CNT_W'(1);
            prot_ctl.set_en  = req_q.protect_flag;
          end else begin
            res_next.status = rfla_pkg::ST_EXHAUSTED;
          end
        end
        rfla_pkg::OP_FREE: begin
          if (prot_hit && !req_q.force_flag) begin
            res_next.status = rfla_pkg::ST_HELD;
          end else begin
            prot_ctl.clr_en = prot_hit;
            if (stk_st.full) begin
              res_next.status = rfla_pkg::ST_OVERFLOW;
            end else begin
              stk_ctl.push = 1'b1;
            end
          end
        end
        rfla_pkg::OP_RESET: begin
          fresh_next       = '0;
          stk_ctl.clr      = 1'b1;
          prot_ctl.clr_all = 1'b1;
        end
        default: begin
        end
      endcase
    end
    prot_ctl.set_idx = res_next.reg_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= '0;
      done  <= 1'b0;
    end else begin
      fresh <= fresh_next;
      done  <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    req_valid |=> done)
    else $error("request without result");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    done && res.status != rfla_pkg::ST_OK |-> res.reg_out == '0)
    else $error("failed request returned a register number");

  a_stack_sane: assert property (@(posedge clk) disable iff (rst)
    !(stk_st.empty && stk_st.full))
    else $error("stack both empty and full");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh <= rfla_pkg::CNT_W'(LIMIT))
    else $error("fresh counter past limit");

endmodule

// ===== bench/tb_register_free_list_allocator.sv =====
module tb_register_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGS = 256;
  localparam int LIMIT = (NUM_REGS > rfla_pkg::REG_SPACE) ? rfla_pkg::REG_SPACE : NUM_REGS;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  rfla_pkg::req_t req = '0;
  logic busy;
  logic done;
  rfla_pkg::res_t res;

  register_free_list_allocator #(.NUM_REGS(NUM_REGS)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator state as predicted
  int unsigned next_fresh;
  int unsigned freed_depth;
  logic [rfla_pkg::REG_W-1:0] freed_regs [rfla_pkg::REG_SPACE];
  bit guarded [rfla_pkg::REG_SPACE];

  rfla_pkg::res_t expected_results [$];
  logic [rfla_pkg::REG_W-1:0] live_regs [$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  task automatic clear_allocator();
    next_fresh = 0;
    freed_depth = 0;
    foreach (guarded[i]) guarded[i] = 1'b0;
    live_regs.delete();
  endtask

  task automatic predict_allocation(input rfla_pkg::req_t r);
    rfla_pkg::res_t e;
    bit pass_on;
    e = '0;
    e.status = rfla_pkg::ST_OK;
    case (r.req_type)
      rfla_pkg::OP_GET: begin
        pass_on = 1'b1;
        if (freed_depth > 0) begin
          freed_depth--;
          e.reg_out = freed_regs[freed_depth];
        end else if (next_fresh < LIMIT) begin
          e.reg_out = rfla_pkg::REG_W'(next_fresh);
          next_fresh++;
        end else begin
          pass_on = 1'b0;
          e.status = rfla_pkg::ST_EXHAUSTED;
        end
        if (pass_on) begin
          if (r.protect_flag) guarded[e.reg_out] = 1'b1;
          live_regs.insert(live_regs.size(), e.reg_out);
        end
      end
      rfla_pkg::OP_FREE: begin
        pass_on = 1'b1;
        if (guarded[r.reg_in]) begin
          if (!r.force_flag) begin
            pass_on = 1'b0;
            e.status = rfla_pkg::ST_HELD;
            // still out, keep it available for a later free
            live_regs.insert(live_regs.size(), r.reg_in);
          end else begin
            guarded[r.reg_in] = 1'b0;
          end
        end
        if (pass_on) begin
          if (freed_depth >= LIMIT) begin
            e.status = rfla_pkg::ST_OVERFLOW;
          end else begin
            freed_regs[freed_depth] = r.reg_in;
            freed_depth++;
          end
        end
      end
      rfla_pkg::OP_RESET: clear_allocator();
      default: ;
    endcase
    expected_results.insert(expected_results.size(), e);
  endtask

  // one beat on the request channel, bursts separated by random gaps that may be empty
  task automatic send_beat(input rfla_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    predict_allocation(r);
  endtask

  task automatic issue(input logic [1:0] op, input logic prot,
                       input logic [rfla_pkg::REG_W-1:0] regn, input logic frc);
    rfla_pkg::req_t r;
    r.req_type = op;
    r.protect_flag = prot;
    r.reg_in = regn;
    r.force_flag = frc;
    send_beat(r);
  endtask

  task automatic issue_get(input logic prot);
    issue(rfla_pkg::OP_GET, prot, rfla_pkg::REG_W'($urandom), 1'($urandom));
  endtask

  task automatic issue_free(input logic [rfla_pkg::REG_W-1:0] regn, input logic frc);
    issue(rfla_pkg::OP_FREE, 1'($urandom), regn, frc);
  endtask

  task automatic test_fresh_and_lifo();
    issue_get(1'b0);
    issue_get(1'b0);
    issue_get(1'b0);
    issue_free(8'd1, 1'b0);
    issue_free(8'd2, 1'b1);
    issue_get(1'b0);
    issue_get(1'b0);
    // numbers never handed out go on the stack unchecked
    issue_free(8'd255, 1'b0);
    issue_get(1'b0);
    issue_free(8'd0, 1'b0);
    issue_get(1'b0);
    issue(OP_NOP, 1'b1, 8'hff, 1'b1);
    issue(OP_NOP, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_protection();
    issue_get(1'b1);
    issue_free(8'd3, 1'b0);
    issue_free(8'd3, 1'b1);
    issue_get(1'b0);
    issue_free(8'd3, 1'b0);
    // double free, then protect the same number twice
    issue_free(8'd3, 1'b0);
    issue_get(1'b1);
    issue_get(1'b1);
    issue_free(8'd3, 1'b1);
    issue_free(8'd3, 1'b0);
  endtask

  task automatic test_reset_request();
    issue_get(1'b1);
    issue(rfla_pkg::OP_RESET, 1'b1, 8'hff, 1'b1);
    issue_get(1'b0);
    issue_free(8'd4, 1'b0);
    issue(rfla_pkg::OP_RESET, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_exhaustion();
    issue(rfla_pkg::OP_RESET, 1'b0, 8'h00, 1'b0);
    repeat (LIMIT) issue_get(1'($urandom_range(0, 7) == 0));
    issue_get(1'b1);
    issue_get(1'b0);
    issue_free(8'd7, 1'b1);
    issue_get(1'b0);
    issue_get(1'b0);
  endtask

  task automatic test_overflow();
    issue(rfla_pkg::OP_RESET, 1'b0, 8'h00, 1'b0);
    issue_get(1'b1);
    repeat (LIMIT) issue_free(rfla_pkg::REG_W'($urandom_range(1, 255)), 1'b0);
    issue_free(8'd0, 1'b0);
    // forced release on a full stack: dropped, but protection stays cleared
    issue_free(8'd0, 1'b1);
    issue_free(8'd0, 1'b0);
    issue_free(8'd255, 1'b1);
    issue_get(1'b0);
    issue_free(8'd0, 1'b0);
    issue(rfla_pkg::OP_RESET, 1'b0, 8'h00, 1'b0);
  endtask

  task automatic test_random_mix(input int count, input int get_pct, input int free_pct,
                                 input int reset_pct);
    int roll;
    int idx;
    logic [rfla_pkg::REG_W-1:0] regn;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < get_pct) begin
        issue_get(1'($urandom_range(0, 2) == 0));
      end else if (roll < get_pct + free_pct) begin
        if (live_regs.size() > 0 && $urandom_range(0, 3) != 0) begin
          idx = $urandom_range(0, live_regs.size() - 1);
          regn = live_regs[idx];
          live_regs.delete(idx);
        end else begin
          regn = rfla_pkg::REG_W'($urandom_range(0, 255));
        end
        issue_free(regn, 1'($urandom));
      end else if (roll < get_pct + free_pct + reset_pct) begin
        issue(rfla_pkg::OP_RESET, 1'($urandom), rfla_pkg::REG_W'($urandom), 1'($urandom));
      end else begin
        issue(OP_NOP, 1'($urandom), rfla_pkg::REG_W'($urandom), 1'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    rfla_pkg::res_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result reg_out %0d status %0d", $time,
                 res.reg_out, res.status);
      end else begin
        want = expected_results.pop_front();
        if (res.reg_out !== want.reg_out) begin
          errors++;
          $display("%0t: reg_out expected %0d actual %0d", $time, want.reg_out, res.reg_out);
        end
        if (res.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, res.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("register_free_list_allocator regression: fail");
      $finish;
    end
  end

  initial begin
    clear_allocator();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_fresh_and_lifo();
    test_protection();
    test_reset_request();
    test_exhaustion();
    test_overflow();
    test_random_mix(350, 45, 45, 2);
    test_random_mix(250, 85, 10, 0);
    test_random_mix(250, 10, 85, 0);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("register_free_list_allocator regression: pass");
    end else begin
      $display("register_free_list_allocator regression: fail");
    end
    $finish;
  end

endmodule
